[hdl/stepgen_pkg.sv]
// Shared types, constants and small functions of the stepper step generator.
// Used by the divider, the motor engine and the top level; depends on nothing.
package stepgen_pkg;

    // Dither table length per motor and number of motor channels
    localparam int DITHER_LEN = 10;
    localparam int NUM_MOTORS = 3;

    // Field widths
    localparam int MOT_W   = 2;
    localparam int SPEED_W = 7;
    localparam int STEP_W  = 32;
    localparam int NUM_W   = 11;
    localparam int WAIT_W  = 8;
    localparam int PHASE_W = 4;
    localparam int COIL_W  = 8;
    localparam int POS_W   = (DITHER_LEN > 1) ? $clog2(DITHER_LEN) : 1;
    localparam int CNT_W   = $clog2(DITHER_LEN + 1);
    localparam int TAB_DEPTH = NUM_MOTORS * DITHER_LEN;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);

    // Divider operand widths
    localparam int DIVD_W = NUM_W;
    localparam int DIVS_W = SPEED_W;

    localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(800);

    // Item kinds carried in tuser
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_CMD  = 1'b1;

    // Motor indexes
    localparam logic [MOT_W-1:0] LEFT_MOTOR  = 2'd0;
    localparam logic [MOT_W-1:0] RIGHT_MOTOR = 2'd1;
    localparam logic [MOT_W-1:0] GRIP_MOTOR  = 2'd2;

    localparam logic [PHASE_W-1:0] PHASE_OFF = 4'd8;
    localparam logic [WAIT_W-1:0]  WAIT_MAX  = 8'hFF;

    typedef struct packed {
        logic [STEP_W-1:0]  step_count;
        logic [SPEED_W-1:0] speed_pct;
        logic               dir_ccw;
        logic [MOT_W-1:0]   motor_sel;
        logic               mode;
    } t_item;

    typedef struct packed {
        logic [NUM_MOTORS-1:0] running_mask;
        logic [COIL_W-1:0]     coil_high;
        logic [COIL_W-1:0]     coil_low;
    } t_result;

    // One motor's entry in the state memory
    typedef struct packed {
        logic [POS_W-1:0]   dither_pos;
        logic [WAIT_W-1:0]  wait_count;
        logic [PHASE_W-1:0] phase;
        logic [STEP_W-1:0]  steps_left;
        logic               running;
        logic               dir_neg;
    } t_mstate;

    // Half-step coil patterns; anything past the last phase releases the coils.
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] p);
        logic [COIL_W-1:0] pat;
        case (p)
            4'd0:    pat = 8'h10;
            4'd1:    pat = 8'h30;
            4'd2:    pat = 8'h20;
            4'd3:    pat = 8'h60;
            4'd4:    pat = 8'h40;
            4'd5:    pat = 8'hC0;
            4'd6:    pat = 8'h80;
            4'd7:    pat = 8'h90;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

    // First dither table address of a motor
    function automatic logic [TAB_AW-1:0] motor_base(input logic [MOT_W-1:0] m);
        return TAB_AW'(int'(m) * DITHER_LEN);
    endfunction

endpackage

[hdl/stepgen_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on stepgen_pkg for the operand widths.
module stepgen_div
    import stepgen_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient,
    output logic [DIVS_W-1:0] o_remainder
);

    localparam int DCNT_W = $clog2(DIVD_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [DIVS_W-1:0] r_rem, n_rem;
    logic [DIVS_W-1:0] r_dvs, n_dvs;

    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W+1:0] diff;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(DIVD_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DIVD_W-2:0], !diff[DIVS_W+1]};
            n_rem = diff[DIVS_W+1] ? rem_sh[DIVS_W-1:0] : diff[DIVS_W-1:0];
            n_cnt = r_cnt - DCNT_W'(1);
            if (r_cnt == DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[hdl/stepgen_engine.sv]
// Motor engine: state memory, dither table memory and the sequencer that
// reads, updates and writes them back. Depends on stepgen_pkg and stepgen_div.
module stepgen_engine
    import stepgen_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_item            i_item,
    input  logic [NUM_W-1:0] i_numerator,
    output logic             o_idle,
    output logic             o_done,
    input  logic             i_ack,
    output t_result          o_result
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_TAB  = 4'd2;
    localparam logic [3:0] S_TWR  = 4'd3;
    localparam logic [3:0] S_STOP = 4'd4;
    localparam logic [3:0] S_DIV1 = 4'd5;
    localparam logic [3:0] S_DIV2 = 4'd6;
    localparam logic [3:0] S_FILL = 4'd7;
    localparam logic [3:0] S_CWR  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]        r_fsm, n_fsm;
    logic [MOT_W-1:0]  r_m, n_m;
    logic [CNT_W-1:0]  r_i, n_i;
    t_item             r_item;
    logic [DIVD_W-1:0] r_base;
    logic [CNT_W-1:0]  r_remq;

    // Per-motor state memory, with a valid bit per entry for the reset value
    t_mstate               r_st_mem [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] r_valid;
    t_mstate               r_st_q;
    logic                  st_we;
    t_mstate               st_wdata;

    // Dither table memory
    logic [WAIT_W-1:0] r_tab [TAB_DEPTH];
    logic [WAIT_W-1:0] r_tab_q;
    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr;
    logic [TAB_AW-1:0] tab_raddr;
    logic [WAIT_W-1:0] tab_wdata;

    // Output-facing copies of phase and running
    logic [PHASE_W-1:0]    r_phase [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] r_run;

    logic              div_start, div_busy, div_done;
    logic [DIVD_W-1:0] div_dividend, div_quo;
    logic [DIVS_W-1:0] div_rem;

    logic [WAIT_W-1:0] sat0, sat1;
    logic [CNT_W-1:0]  thresh;
    t_mstate           tick_state;
    logic [PHASE_W:0]  p5;

    stepgen_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_item.speed_pct),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign div_dividend = (r_fsm == S_RD) ? i_numerator
                                          : DIVD_W'(div_rem) * DIVD_W'(DITHER_LEN);

    // Saturated waits: the longer one fills the front of the table
    assign sat0   = (r_base > DIVD_W'(WAIT_MAX)) ? WAIT_MAX : r_base[WAIT_W-1:0];
    assign sat1   = (r_base >= DIVD_W'(WAIT_MAX)) ? WAIT_MAX
                                                  : r_base[WAIT_W-1:0] + WAIT_W'(1);
    assign thresh = CNT_W'(DITHER_LEN) - r_remq;

    assign tab_raddr = motor_base(r_m) + TAB_AW'(r_st_q.dither_pos);
    assign tab_waddr = motor_base(r_m) + TAB_AW'(r_i);
    assign tab_wdata = (r_i < thresh) ? sat1 : sat0;

    // One timer tick applied to the motor just read
    always_comb begin
        tick_state = r_st_q;
        p5 = {1'b0, r_st_q.phase};
        if (r_st_q.steps_left > STEP_W'(1)) begin
            if (r_st_q.wait_count == '0) begin
                p5 = r_st_q.dir_neg ? p5 - (PHASE_W+1)'(1) : p5 + (PHASE_W+1)'(1);
                if (r_st_q.steps_left != '1) begin
                    tick_state.steps_left = r_st_q.steps_left - STEP_W'(1);
                end
                tick_state.wait_count = r_tab_q;
                tick_state.dither_pos = (r_st_q.dither_pos == POS_W'(DITHER_LEN - 1))
                                        ? '0 : r_st_q.dither_pos + POS_W'(1);
            end else begin
                tick_state.wait_count = r_st_q.wait_count - WAIT_W'(1);
            end
        end else begin
            tick_state.steps_left = '0;
            tick_state.running    = 1'b0;
            tick_state.wait_count = '0;
        end
        if (p5[PHASE_W]) begin
            tick_state.phase = PHASE_W'(7);
        end else if (p5 >= (PHASE_W+1)'(8)) begin
            tick_state.phase = '0;
        end else begin
            tick_state.phase = p5[PHASE_W-1:0];
        end
        if (!tick_state.running) begin
            tick_state.phase = PHASE_OFF;
        end
    end

    always_comb begin
        n_fsm     = r_fsm;
        n_m       = r_m;
        n_i       = r_i;
        div_start = 1'b0;
        tab_we    = 1'b0;
        st_we     = 1'b0;
        st_wdata  = tick_state;
        case (r_fsm)
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.mode == MODE_TICK) begin
                        n_m   = LEFT_MOTOR;
                        n_fsm = S_RD;
                    end else if (i_item.motor_sel >= MOT_W'(NUM_MOTORS)) begin
                        n_fsm = S_FIN;
                    end else begin
                        n_m   = i_item.motor_sel;
                        n_fsm = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_item.mode == MODE_TICK) begin
                    n_fsm = S_TAB;
                end else if (r_item.speed_pct == '0) begin
                    n_fsm = S_STOP;
                end else begin
                    div_start = 1'b1;
                    n_fsm     = S_DIV1;
                end
            end
            S_TAB: begin
                n_fsm = S_TWR;
            end
            S_TWR: begin
                st_we = 1'b1;
                if (r_m == MOT_W'(NUM_MOTORS - 1)) begin
                    n_fsm = S_FIN;
                end else begin
                    n_m   = r_m + MOT_W'(1);
                    n_fsm = S_RD;
                end
            end
            S_STOP: begin
                st_we               = 1'b1;
                st_wdata            = r_st_q;
                st_wdata.steps_left = '0;
                st_wdata.running    = 1'b0;
                n_fsm               = S_FIN;
            end
            S_DIV1: begin
                if (div_done) begin
                    div_start = 1'b1;
                    n_fsm     = S_DIV2;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    n_i   = '0;
                    n_fsm = S_FILL;
                end
            end
            S_FILL: begin
                tab_we = 1'b1;
                n_i    = r_i + CNT_W'(1);
                if (r_i == CNT_W'(DITHER_LEN - 1)) begin
                    n_fsm = S_CWR;
                end
            end
            S_CWR: begin
                st_we               = 1'b1;
                st_wdata            = r_st_q;
                st_wdata.dither_pos = '0;
                st_wdata.wait_count = sat1;
                st_wdata.steps_left = r_item.step_count;
                st_wdata.running    = 1'b1;
                st_wdata.dir_neg    = r_item.dir_ccw;
                n_fsm               = S_FIN;
            end
            S_FIN: begin
                if (i_ack) begin
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_m     <= '0;
            r_i     <= '0;
            r_valid <= '0;
            r_run   <= '0;
            for (int k = 0; k < NUM_MOTORS; k++) begin
                r_phase[k] <= '0;
            end
        end else begin
            r_fsm <= n_fsm;
            r_m   <= n_m;
            r_i   <= n_i;
            if (st_we) begin
                r_valid[r_m] <= 1'b1;
                r_run[r_m]   <= st_wdata.running;
                r_phase[r_m] <= st_wdata.phase;
            end
        end
        if (r_fsm == S_IDLE && i_start) begin
            r_item <= i_item;
        end
        if (r_fsm == S_DIV1 && div_done) begin
            r_base <= div_quo;
        end
        if (r_fsm == S_DIV2 && div_done) begin
            r_remq <= div_quo[CNT_W-1:0];
        end
    end

    // State memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[r_m] <= st_wdata;
        end
        r_st_q <= (r_m < MOT_W'(NUM_MOTORS) && r_valid[r_m]) ? r_st_mem[r_m] : '0;
    end

    // Dither table memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_waddr] <= tab_wdata;
        end
        r_tab_q <= r_tab[tab_raddr];
    end

    assign o_idle = (r_fsm == S_IDLE);
    assign o_done = (r_fsm == S_FIN);
    assign o_result.coil_low  = (coil_pattern(r_phase[RIGHT_MOTOR]) >> 4)
                              | coil_pattern(r_phase[GRIP_MOTOR]);
    assign o_result.coil_high = coil_pattern(r_phase[LEFT_MOTOR]);
    assign o_result.running_mask = r_run;

    a_st_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> r_m < MOT_W'(NUM_MOTORS))
        else $error("state memory written beyond the last motor");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_coils_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st_we && r_fsm == S_TWR && !st_wdata.running) |-> st_wdata.phase == PHASE_OFF)
        else $error("stopped motor keeps its coils energised after a tick");

    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_CWR) |-> $past(r_fsm) == S_FILL)
        else $error("command state written before the dither table was filled");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_FIN && !i_ack) |=> r_fsm == S_FIN)
        else $error("result dropped before it was handed over");

endmodule

[hdl/stepper_step_generator_top.sv]
// Top level of the three-channel half-step stepper step generator.
// Depends on stepgen_pkg and stepgen_engine.
//
// Use: items arrive as beats on the s_axis channel. tuser = 0 marks a timer
// tick, which advances all three motors; tuser = 1 marks a motor command,
// which sets one motor's direction, speed and step count, or stops the motor
// when the speed is zero. Every item gives exactly one result beat on m_axis:
// the coil bytes and the running mask. The cfg channel writes the wait
// numerator and is always ready; the user must see that it is written only
// while the block is idle, as the block itself does not enforce this. A tick
// makes three read-modify-write passes over the state memory, one per motor,
// then hands its result over. A command with nonzero speed runs two passes of
// the bit-serial divider and fills the motor's dither table; a stop writes the
// motor's state, and a command to a missing motor goes straight to the
// hand-over. One item is in work at a time; the next is taken at the edge
// after the previous result has moved to the output register.
// Reset (synchronous, active low) stops all motors, sets every phase to the
// first coil pattern and the numerator to 800. When the receiver stalls the
// result waits in the output register; a further result waits in the engine
// and holds off new input beats until the register drains.
module stepper_step_generator_top
    import stepgen_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input items
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [1:0] motor_sel, [2] dir_ccw, [9:3] speed_pct, [41:10] step_count, rest zero
    input  logic [47:0]        s_axis_tdata,
    // [0] mode
    input  logic               s_axis_tuser,
    // Result items
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [7:0] coil_low, [15:8] coil_high, [18:16] running_mask, rest zero
    output logic [23:0]        m_axis_tdata,
    // Wait numerator register
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [NUM_W-1:0]   i_cfg_data
);

    logic [NUM_W-1:0] r_numerator;
    logic             r_out_valid;
    t_result          r_out;

    t_item   item;
    t_result eng_result;
    logic    eng_idle, eng_done, eng_ack, in_beat;

    // Unpack the input beat into the item fields
    assign item.mode       = s_axis_tuser;
    assign item.motor_sel  = s_axis_tdata[1:0];
    assign item.dir_ccw    = s_axis_tdata[2];
    assign item.speed_pct  = s_axis_tdata[9:3];
    assign item.step_count = s_axis_tdata[41:10];

    assign s_axis_tready = eng_idle;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // The engine hands its result over whenever the output register is free
    // or being emptied in the same cycle.
    assign eng_ack = eng_done && (!r_out_valid || m_axis_tready);

    stepgen_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_beat),
        .i_item      (item),
        .i_numerator (r_numerator),
        .o_idle      (eng_idle),
        .o_done      (eng_done),
        .i_ack       (eng_ack),
        .o_result    (eng_result)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numerator <= NUM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_numerator <= i_cfg_data;
            end
            if (eng_ack) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (eng_ack) begin
            r_out <= eng_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.running_mask, r_out.coil_high, r_out.coil_low};

endmodule

[verif/tb_stepper_step_generator_top.sv]
// Self-checking testbench for the three-channel stepper step generator.
// Predicts coil bytes and running mask for every beat; needs stepgen_pkg and the top level.
`timescale 1ns / 100ps

module tb_stepper_step_generator_top;
    import stepgen_pkg::*;

    // Motor select value that addresses no motor; the block must ignore such commands.
    localparam logic [MOT_W-1:0] MOTOR_NONE = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any accepted beat
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int RUN_ITEMS      = 100;   // random beats per numerator setting
    localparam int SETTLE_CYCLES  = 60;    // beyond the slowest command latency

    // Receiver behaviour, chosen afresh for each stretch of cycles.
    typedef enum logic [1:0] {
        RX_FREE,      // always ready
        RX_COIN,      // ready half of the time
        RX_SPARSE,    // ready one cycle in four on average
        RX_PERIODIC   // stalls in a regular repeating pattern
    } t_rx_mode;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata  = '0;
    logic               s_axis_tuser  = MODE_TICK;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [23:0]        m_axis_tdata;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [NUM_W-1:0]   i_cfg_data    = '0;

    stepper_step_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Motor predictor: our own copy of every motor's state and of the
    // wait numerator, advanced once per accepted input beat.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]   pm_numerator;
    logic [7:0]         pm_waits     [NUM_MOTORS][DITHER_LEN];
    logic [3:0]         pm_slot      [NUM_MOTORS];
    logic [8:0]         pm_countdown [NUM_MOTORS];
    logic [PHASE_W-1:0] pm_phase     [NUM_MOTORS];
    logic [STEP_W-1:0]  pm_remaining [NUM_MOTORS];
    logic               pm_active    [NUM_MOTORS];
    logic               pm_reverse   [NUM_MOTORS];

    // Results still owed by the block, oldest first.
    t_result            coil_results_due[$];
    int                 mismatch_count = 0;

    // Sender burst bookkeeping.
    int unsigned        burst_left = 0;
    bit                 offering   = 1'b0;

    // Receiver hold-off request, raised once by the back-pressure test.
    bit                 hold_pending = 1'b0;

    task automatic reset_predictor();
        pm_numerator = NUM_RESET;
        for (int m = 0; m < NUM_MOTORS; m++) begin
            for (int i = 0; i < DITHER_LEN; i++) begin
                pm_waits[m][i] = 8'd0;
            end
            pm_slot[m]      = '0;
            pm_countdown[m] = '0;
            pm_phase[m]     = '0;
            pm_remaining[m] = '0;
            pm_active[m]    = 1'b0;
            pm_reverse[m]   = 1'b0;
        end
    endtask

    // Half-step pattern: the leading coil, plus the next coil round on odd
    // phases. Any phase past the eighth releases all coils.
    function automatic logic [7:0] coil_bits(input logic [PHASE_W-1:0] p);
        logic [7:0] pat;
        if (p >= PHASE_OFF) begin
            return 8'h00;
        end
        pat = 8'h10 << p[2:1];
        if (p[0]) begin
            pat = pat | (8'h10 << 2'(p[2:1] + 2'd1));
        end
        return pat;
    endfunction

    // Applies one input item to the predicted motor state and returns the
    // result beat that the block should produce for it.
    function automatic t_result predict_coils(input t_item item);
        t_result     res;
        int unsigned base, rem, w;
        int          m, i, p;
        if (item.mode == MODE_CMD) begin
            m = int'(item.motor_sel);
            if (item.motor_sel != MOTOR_NONE) begin
                if (item.speed_pct == '0) begin
                    pm_remaining[m] = '0;
                    pm_active[m]    = 1'b0;
                end else begin
                    base = pm_numerator / item.speed_pct;
                    rem  = ((pm_numerator % item.speed_pct) * DITHER_LEN) / item.speed_pct;
                    for (i = 0; i < DITHER_LEN; i++) begin
                        w = (i < DITHER_LEN - rem) ? base + 1 : base;
                        pm_waits[m][i] = (w > 255) ? 8'hFF : 8'(w);
                    end
                    pm_slot[m]      = '0;
                    pm_countdown[m] = 9'(pm_waits[m][0]);
                    pm_remaining[m] = item.step_count;
                    pm_reverse[m]   = item.dir_ccw;
                    pm_active[m]    = 1'b1;
                end
            end
        end else begin
            for (m = 0; m < NUM_MOTORS; m++) begin
                p = int'(pm_phase[m]);
                if (pm_remaining[m] > 1) begin
                    if (pm_countdown[m] == '0) begin
                        p = pm_reverse[m] ? p - 1 : p + 1;
                        // An all-ones count means run without end.
                        if (pm_remaining[m] != '1) begin
                            pm_remaining[m] = pm_remaining[m] - 1;
                        end
                        pm_countdown[m] = 9'(pm_waits[m][pm_slot[m] % DITHER_LEN]);
                        pm_slot[m] = (pm_slot[m] + 1 >= DITHER_LEN) ? 4'd0
                                                                     : 4'(pm_slot[m] + 1);
                    end else begin
                        pm_countdown[m] = 9'(pm_countdown[m] - 1);
                    end
                end else begin
                    pm_remaining[m] = '0;
                    pm_active[m]    = 1'b0;
                    pm_countdown[m] = '0;
                end
                if (p >= 8) begin
                    p = 0;
                end else if (p < 0) begin
                    p = 7;
                end
                pm_phase[m] = pm_active[m] ? PHASE_W'(p) : PHASE_OFF;
            end
        end
        res.coil_low     = (coil_bits(pm_phase[1]) >> 4) | coil_bits(pm_phase[2]);
        res.coil_high    = coil_bits(pm_phase[0]);
        res.running_mask = {pm_active[2], pm_active[1], pm_active[0]};
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic t_item tick_item();
        t_item item;
        item      = '0;
        item.mode = MODE_TICK;
        return item;
    endfunction

    function automatic t_item command_item(input logic [MOT_W-1:0] motor, input logic ccw,
                                           input logic [SPEED_W-1:0] speed,
                                           input logic [STEP_W-1:0] steps);
        t_item item;
        item.mode       = MODE_CMD;
        item.motor_sel  = motor;
        item.dir_ccw    = ccw;
        item.speed_pct  = speed;
        item.step_count = steps;
        return item;
    endfunction

    // Mostly ticks, so that commanded runs play out; commands carry short
    // finite runs, endless runs, stops and out-of-range speeds.
    function automatic t_item random_item();
        t_item       item;
        int unsigned pick;
        item.mode      = ($urandom_range(0, 99) < 15) ? MODE_CMD : MODE_TICK;
        item.motor_sel = ($urandom_range(0, 19) == 0) ? MOTOR_NONE : MOT_W'($urandom_range(0, 2));
        item.dir_ccw   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            item.speed_pct = '0;
        end else if (pick < 15) begin
            item.speed_pct = SPEED_W'($urandom_range(101, 127));
        end else begin
            item.speed_pct = SPEED_W'($urandom_range(1, 100));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            item.step_count = STEP_W'($urandom_range(0, 1));
        end else if (pick < 20) begin
            item.step_count = '1;
        end else if (pick < 40) begin
            item.step_count = $urandom();
        end else begin
            item.step_count = STEP_W'($urandom_range(2, 40));
        end
        return item;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers beats in bursts of random length, with tvalid dropped in a
    // gap between bursts. Returns at the edge that accepted the beat, leaving
    // tvalid high for the next one.
    // ------------------------------------------------------------------
    task automatic send_item(input t_item item);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(1, 12);
            if (offering) begin
                s_axis_tvalid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= item.mode;
        s_axis_tdata  <= {6'd0, item.step_count, item.speed_pct, item.dir_ccw, item.motor_sel};
        offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        coil_results_due.push_back(predict_coils(item));
    endtask

    // Withdraws tvalid after the last beat of a test.
    task automatic end_burst();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        burst_left = 0;
    endtask

    // Writes the wait numerator once the block has returned every result.
    task automatic write_numerator(input logic [NUM_W-1:0] value);
        while (coil_results_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pm_numerator = value;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls on a pattern of its own, switching mode after a stretch
    // of random length, and once holds off for a long stretch on request.
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode      = RX_FREE;
    int unsigned rx_left      = 0;
    int unsigned rx_phase     = 0;
    int unsigned hold_left    = 0;
    bit          hold_taken   = 1'b0;

    always @(posedge i_clk) begin
        rx_phase = rx_phase + 1;
        if (hold_pending && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(10, 150);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:     m_axis_tready <= 1'b1;
                RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:     m_axis_tready <= (rx_phase % 4 != 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result beat is compared field by
    // field with the oldest outstanding prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[18:0];
            if (coil_results_due.size() == 0) begin
                $error("result beat %h arrived with no result outstanding", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = coil_results_due.pop_front();
                if (got.coil_low !== want.coil_low) begin
                    $error("coil_low: expected %02h, got %02h", want.coil_low, got.coil_low);
                    mismatch_count++;
                end
                if (got.coil_high !== want.coil_high) begin
                    $error("coil_high: expected %02h, got %02h", want.coil_high, got.coil_high);
                    mismatch_count++;
                end
                if (got.running_mask !== want.running_mask) begin
                    $error("running_mask: expected %03b, got %03b",
                           want.running_mask, got.running_mask);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if no beat moves on any channel for too long.
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After reset every motor is stopped with its first coil pattern on;
    // a command to the missing fourth motor shows that state unchanged,
    // and the first tick releases the coils.
    task automatic test_reset_state();
        send_item(command_item(MOTOR_NONE, 1'b0, 7'd50, 32'd10));
        send_item(tick_item());
        send_item(tick_item());
        end_burst();
    endtask

    // Short directed runs with a numerator of one, so that steps come
    // every tick or two: both directions, an endless run wrapping below
    // phase zero, a stop after a finished run, an ignored motor, and counts of 0 and 1.
    task automatic test_directed_moves();
        write_numerator(11'd1);
        send_item(command_item(LEFT_MOTOR, 1'b0, 7'd100, 32'd4));
        send_item(command_item(RIGHT_MOTOR, 1'b1, 7'd127, 32'hFFFF_FFFF));
        send_item(command_item(GRIP_MOTOR, 1'b0, 7'd3, 32'd2));
        repeat (8) send_item(tick_item());
        send_item(command_item(LEFT_MOTOR, 1'b1, 7'd0, 32'd100));
        send_item(tick_item());
        send_item(command_item(MOTOR_NONE, 1'b1, 7'd127, 32'hFFFF_FFFF));
        send_item(command_item(GRIP_MOTOR, 1'b1, 7'd50, 32'd0));
        send_item(command_item(LEFT_MOTOR, 1'b0, 7'd1, 32'd1));
        send_item(tick_item());
        send_item(tick_item());
        end_burst();
    endtask

    // With a numerator of 2000 a slow speed asks for waits far above
    // 255, which must saturate.
    task automatic test_wait_saturation();
        write_numerator(11'd2000);
        send_item(command_item(LEFT_MOTOR, 1'b0, 7'd1, 32'd5));
        send_item(command_item(RIGHT_MOTOR, 1'b0, 7'd0, 32'd0));
        send_item(tick_item());
        send_item(tick_item());
        send_item(command_item(LEFT_MOTOR, 1'b0, 7'd0, 32'd0));
        end_burst();
    endtask

    // Random commands and ticks under one numerator setting.
    task automatic test_random_runs(input logic [NUM_W-1:0] numerator);
        write_numerator(numerator);
        repeat (RUN_ITEMS) send_item(random_item());
        end_burst();
    endtask

    // The receiver holds off for a long stretch while beats keep coming,
    // so the output register and the engine fill and tready drops.
    task automatic test_back_pressure();
        hold_pending = 1'b1;
        repeat (30) send_item(random_item());
        end_burst();
    endtask

    initial begin
        reset_predictor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_moves();
        test_wait_saturation();
        test_random_runs(11'd1);
        test_random_runs(11'd2000);
        test_back_pressure();
        test_random_runs(NUM_RESET);
        test_random_runs(NUM_W'($urandom_range(2, 40)));
        test_random_runs(11'd1023);

        // Drain, then allow time for any stray result beat to show up.
        while (coil_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
